// ===== src/sme_pkg.sv =====
// Package: field widths, operation codes, sequencer steps and microcode table.
package sme_pkg;

	localparam int PARTY_COUNT_DEF = 8;
	localparam int FIELD_W         = 3;
	localparam int OP_W            = 2;
	localparam int RESULT_MAX      = 2 ** FIELD_W;

	typedef enum logic [OP_W-1:0] {
		OP_DEPT_RANK   = 2'd0,
		OP_PROG_CHOICE = 2'd1,
		OP_RUN         = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_PICK,
		ST_FETCH,
		ST_RNEW,
		ST_ROLD,
		ST_EMIT
	} step_t;

	typedef enum logic [2:0] {
		COND_ALWAYS,
		COND_RUN,
		COND_NO_PROP,
		COND_SETTLED,
		COND_LAST
	} cond_t;

	typedef struct packed {
		logic  in_rdy;
		logic  clr;
		logic  pick;
		logic  fetch;
		logic  cmp_new;
		logic  cmp_old;
		logic  emit;
		cond_t cond;
		step_t target;
		step_t seq;
	} ctl_word_t;

	function automatic ctl_word_t ucode(step_t s);
		ctl_word_t w;
		w        = '0;
		w.cond   = COND_ALWAYS;
		w.target = ST_IDLE;
		w.seq    = ST_IDLE;
		unique case (s)
			ST_IDLE: begin
				w.in_rdy = 1'b1;
				w.cond   = COND_RUN;
				w.target = ST_INIT;
				w.seq    = ST_IDLE;
			end
			ST_INIT: begin
				w.clr    = 1'b1;
				w.target = ST_PICK;
			end
			ST_PICK: begin
				w.pick   = 1'b1;
				w.cond   = COND_NO_PROP;
				w.target = ST_EMIT;
				w.seq    = ST_FETCH;
			end
			ST_FETCH: begin
				w.fetch  = 1'b1;
				w.cond   = COND_SETTLED;
				w.target = ST_PICK;
				w.seq    = ST_RNEW;
			end
			ST_RNEW: begin
				w.cmp_new = 1'b1;
				w.target  = ST_ROLD;
			end
			ST_ROLD: begin
				w.cmp_old = 1'b1;
				w.target  = ST_PICK;
			end
			ST_EMIT: begin
				w.emit   = 1'b1;
				w.cond   = COND_LAST;
				w.target = ST_IDLE;
				w.seq    = ST_EMIT;
			end
			default: begin
				w.target = ST_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

// ===== src/sme_in_if.sv =====
// Interface: command channel carrying table entries and run requests.
interface sme_in_if;
	logic                        valid;
	logic                        ready;
	logic [sme_pkg::OP_W-1:0]    operation;
	logic [sme_pkg::FIELD_W-1:0] person;
	logic [sme_pkg::FIELD_W-1:0] rank;
	logic [sme_pkg::FIELD_W-1:0] choice;

	modport source (output valid, output operation, output person, output rank,
		output choice, input ready);
	modport sink (input valid, input operation, input person, input rank,
		input choice, output ready);
endinterface

// ===== src/sme_out_if.sv =====
// Interface: result channel carrying one department match per item.
interface sme_out_if;
	logic                        valid;
	logic                        ready;
	logic [sme_pkg::FIELD_W-1:0] department;
	logic [sme_pkg::FIELD_W-1:0] programmer;
	logic                        last;

	modport source (output valid, output department, output programmer,
		output last, input ready);
	modport sink (input valid, input department, input programmer,
		input last, output ready);
endinterface

// ===== src/sme_ram.sv =====
// Generic simple dual-port RAM with registered read.
module sme_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/stable_matching_engine_unit.sv =====
// Top level: microcoded stable matching engine with two preference table RAMs.
//
//  channel  | dir | payload                          | handshake
//  cmd      | in  | operation, person, rank, choice  | valid/ready
//  result   | out | department, programmer, last     | valid/ready
//
// Table entries may arrive back to back while idle.
// A run takes an init step, then per proposal a pick and a fetch step, plus rank
// compare steps (new, old) when the department is already held; at most
// PARTY_COUNT^2 proposals, a closing pick, then min(PARTY_COUNT, 8) results.
// The single read port of each table RAM sets the per-proposal step count.
// Reset clears the sequencer and match state; tables are undefined until written.
// cmd stalls for the whole run; a stalled result holds the sequencer in emit.
module stable_matching_engine_unit #(
	parameter int PARTY_COUNT = sme_pkg::PARTY_COUNT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	sme_in_if.sink    cmd,
	sme_out_if.source result
);

	localparam int IDX_W   = $clog2(PARTY_COUNT);
	localparam int CNT_W   = $clog2(PARTY_COUNT + 1);
	localparam int TAB_D   = PARTY_COUNT * PARTY_COUNT;
	localparam int ADDR_W  = $clog2(TAB_D);
	localparam int RES_CAP = (PARTY_COUNT < sme_pkg::RESULT_MAX) ? PARTY_COUNT
		: sme_pkg::RESULT_MAX;
	localparam int D_W     = $clog2(RES_CAP);

	function automatic logic [ADDR_W-1:0] tab_addr(logic [ADDR_W-1:0] row,
		logic [ADDR_W-1:0] col);
		return row * ADDR_W'(PARTY_COUNT) + col;
	endfunction

	sme_pkg::step_t     step_q, step_d;
	sme_pkg::ctl_word_t ctl;
	logic               cond_ok;

	logic [CNT_W-1:0]           np_q [PARTY_COUNT];
	logic [PARTY_COUNT-1:0]     taken_q;
	logic [PARTY_COUNT-1:0]     free_q;
	logic [IDX_W-1:0]           partner_q [PARTY_COUNT];
	logic [IDX_W-1:0]           who_q, dept_q, held_q;
	logic [sme_pkg::FIELD_W-1:0] rnew_q;
	logic [D_W-1:0]             d_q;

	logic                        in_acc, out_acc, is_last;
	logic                        pick_ok;
	logic [IDX_W-1:0]            pick_idx, dept_now, d_idx;
	logic                        dept_bad, take_now, swap_now;
	logic [sme_pkg::FIELD_W-1:0] choice_rdata, rank_rdata;
	logic                        choice_we, rank_we;
	logic [ADDR_W-1:0]           choice_waddr, choice_raddr, rank_waddr, rank_raddr;

	assign ctl        = sme_pkg::ucode(step_q);
	assign cmd.ready  = ctl.in_rdy;
	assign in_acc     = cmd.valid && cmd.ready;
	assign out_acc    = result.valid && result.ready;
	assign is_last    = (d_q == D_W'(RES_CAP - 1));

	always_comb begin
		pick_ok  = 1'b0;
		pick_idx = '0;
		for (int p = PARTY_COUNT - 1; p >= 0; p--) begin
			if (free_q[p] && (np_q[p] < CNT_W'(PARTY_COUNT))) begin
				pick_ok  = 1'b1;
				pick_idx = IDX_W'(p);
			end
		end
	end

	assign dept_now = IDX_W'(choice_rdata);
	assign dept_bad = (choice_rdata >= PARTY_COUNT);
	assign take_now = ctl.fetch && !dept_bad && !taken_q[dept_now];
	assign swap_now = ctl.cmp_old && (rnew_q < rank_rdata);

	always_comb begin
		unique case (ctl.cond)
			sme_pkg::COND_ALWAYS:  cond_ok = 1'b1;
			sme_pkg::COND_RUN:     cond_ok = in_acc && (cmd.operation == sme_pkg::OP_RUN);
			sme_pkg::COND_NO_PROP: cond_ok = !pick_ok;
			sme_pkg::COND_SETTLED: cond_ok = dept_bad || !taken_q[dept_now];
			sme_pkg::COND_LAST:    cond_ok = out_acc && is_last;
			default:               cond_ok = 1'b0;
		endcase
		step_d = cond_ok ? ctl.target : ctl.seq;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= sme_pkg::ST_IDLE;
			taken_q <= '0;
			free_q  <= '1;
			d_q     <= '0;
			for (int p = 0; p < PARTY_COUNT; p++) begin
				np_q[p] <= '0;
			end
		end else begin
			step_q <= step_d;
			if (ctl.clr) begin
				taken_q <= '0;
				free_q  <= '1;
				d_q     <= '0;
				for (int p = 0; p < PARTY_COUNT; p++) begin
					np_q[p] <= '0;
				end
			end
			if (ctl.pick && pick_ok) begin
				np_q[pick_idx] <= np_q[pick_idx] + CNT_W'(1);
			end
			if (take_now) begin
				taken_q[dept_now] <= 1'b1;
				free_q[who_q]     <= 1'b0;
			end
			if (swap_now) begin
				free_q[who_q]  <= 1'b0;
				free_q[held_q] <= 1'b1;
			end
			if (out_acc) begin
				d_q <= d_q + D_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pick && pick_ok) begin
			who_q <= pick_idx;
		end
		if (ctl.fetch) begin
			dept_q <= dept_now;
			held_q <= partner_q[dept_now];
		end
		if (take_now) begin
			partner_q[dept_now] <= who_q;
		end
		if (ctl.cmp_new) begin
			rnew_q <= rank_rdata;
		end
		if (swap_now) begin
			partner_q[dept_q] <= who_q;
		end
	end

	assign choice_we    = in_acc && (cmd.operation == sme_pkg::OP_PROG_CHOICE)
		&& (cmd.person < PARTY_COUNT) && (cmd.rank < PARTY_COUNT);
	assign choice_waddr = tab_addr(ADDR_W'(cmd.person), ADDR_W'(cmd.rank));
	assign choice_raddr = tab_addr(ADDR_W'(pick_idx), ADDR_W'(np_q[pick_idx][IDX_W-1:0]));

	assign rank_we      = in_acc && (cmd.operation == sme_pkg::OP_DEPT_RANK)
		&& (cmd.person < PARTY_COUNT) && (cmd.choice < PARTY_COUNT);
	assign rank_waddr   = tab_addr(ADDR_W'(cmd.person), ADDR_W'(cmd.choice));
	assign rank_raddr   = ctl.fetch ? tab_addr(ADDR_W'(dept_now), ADDR_W'(who_q))
		: tab_addr(ADDR_W'(dept_q), ADDR_W'(held_q));

	sme_ram #(
		.WIDTH (sme_pkg::FIELD_W),
		.DEPTH (TAB_D)
	) u_choice_ram (
		.clk   (clk),
		.we    (choice_we),
		.waddr (choice_waddr),
		.wdata (cmd.choice),
		.raddr (choice_raddr),
		.rdata (choice_rdata)
	);

	sme_ram #(
		.WIDTH (sme_pkg::FIELD_W),
		.DEPTH (TAB_D)
	) u_rank_ram (
		.clk   (clk),
		.we    (rank_we),
		.waddr (rank_waddr),
		.wdata (cmd.rank),
		.raddr (rank_raddr),
		.rdata (rank_rdata)
	);

	assign d_idx             = IDX_W'(d_q);
	assign result.valid      = ctl.emit;
	assign result.department = sme_pkg::FIELD_W'(d_q);
	assign result.programmer = taken_q[d_idx] ? sme_pkg::FIELD_W'(partner_q[d_idx]) : '0;
	assign result.last       = is_last;

endmodule

// ===== sim/sme_match_checker.sv =====
// Checker: predicts stable matching results from observed commands and compares them.
module sme_match_checker (
	input  logic clk,
	input  logic arst_n,
	sme_in_if    cmd,
	sme_out_if   result,
	output int   mismatches,
	output int   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import sme_pkg::*;

	localparam int PARTY   = PARTY_COUNT_DEF;
	localparam int RESULTS = (PARTY < 8) ? PARTY : 8;

	typedef struct {
		logic [FIELD_W-1:0] department;
		logic [FIELD_W-1:0] programmer;
		logic               last;
	} match_t;

	logic [FIELD_W-1:0] pref_list  [PARTY][PARTY];
	logic [FIELD_W-1:0] dept_score [PARTY][PARTY];
	match_t             pending_matches [$];

	function automatic void predict_matching();
		logic [3:0]         next_idx  [PARTY];
		logic [FIELD_W-1:0] holder    [PARTY];
		bit                 taken     [PARTY];
		bit                 free_prog [PARTY];
		int                 who;
		int                 dept;
		match_t             m;
		for (int p = 0; p < PARTY; p++) begin
			next_idx[p]  = '0;
			holder[p]    = '0;
			taken[p]     = 1'b0;
			free_prog[p] = 1'b1;
		end
		forever begin
			who = -1;
			for (int p = PARTY - 1; p >= 0; p--) begin
				if (free_prog[p] && next_idx[p] < PARTY)
					who = p;
			end
			if (who < 0)
				break;
			dept = int'(pref_list[who][next_idx[who]]);
			next_idx[who]++;
			if (dept >= PARTY)
				continue;
			if (!taken[dept]) begin
				taken[dept]    = 1'b1;
				holder[dept]   = FIELD_W'(who);
				free_prog[who] = 1'b0;
			end else if (dept_score[dept][who] < dept_score[dept][holder[dept]]) begin
				free_prog[holder[dept]] = 1'b1;
				holder[dept]            = FIELD_W'(who);
				free_prog[who]          = 1'b0;
			end
		end
		for (int d = 0; d < RESULTS; d++) begin
			m.department = FIELD_W'(d);
			m.programmer = taken[d] ? holder[d] : '0;
			m.last       = (d == RESULTS - 1);
			pending_matches.push_back(m);
		end
	endfunction

	always @(posedge clk) begin
		match_t want;
		if (arst_n) begin
			if (result.valid && result.ready) begin
				if (pending_matches.size() == 0) begin
					$error("unexpected result item: department %0d programmer %0d last %0d",
						result.department, result.programmer, result.last);
					mismatches++;
				end else begin
					want = pending_matches.pop_front();
					if (result.department !== want.department) begin
						$error("department: expected %0d, got %0d",
							want.department, result.department);
						mismatches++;
					end
					if (result.programmer !== want.programmer) begin
						$error("programmer: expected %0d, got %0d",
							want.programmer, result.programmer);
						mismatches++;
					end
					if (result.last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, result.last);
						mismatches++;
					end
				end
			end
			if (cmd.valid && cmd.ready) begin
				case (cmd.operation)
					OP_DEPT_RANK: begin
						if (cmd.person < PARTY && cmd.choice < PARTY)
							dept_score[cmd.person][cmd.choice] = cmd.rank;
					end
					OP_PROG_CHOICE: begin
						if (cmd.person < PARTY && cmd.rank < PARTY)
							pref_list[cmd.person][cmd.rank] = cmd.choice;
					end
					OP_RUN: begin
						predict_matching();
					end
					default: begin
					end
				endcase
			end
			outstanding = pending_matches.size();
		end
	end

endmodule

// ===== sim/stable_matching_engine_unit_tb.sv =====
// Testbench top: clock, reset, command stimulus, result back-pressure and verdict.
module stable_matching_engine_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sme_pkg::*;

	localparam int                PARTY    = PARTY_COUNT_DEF;
	localparam int                RAND_ITEMS = 480;
	localparam logic [OP_W-1:0]   OP_NOISE = 2'd3;

	typedef enum {
		ROW_ASCEND,
		ROW_DESCEND,
		ROW_SHUFFLE,
		ROW_SCATTER,
		ROW_FLAT
	} row_kind_t;

	logic clk = 1'b0;
	logic arst_n;
	bit   calm;
	int   mismatches;
	int   outstanding;
	int   rand_sent;
	bit   drained;

	sme_in_if  cmd_ch ();
	sme_out_if res_ch ();

	stable_matching_engine_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.result (res_ch)
	);

	sme_match_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd_ch),
		.result      (res_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		res_ch.ready <= calm || ($urandom_range(99) >= 18);
	end

	task automatic send_item(input logic [OP_W-1:0] op, input int person, input int rank,
		input int choice);
		while (!calm && $urandom_range(99) < 18) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid     <= 1'b1;
		cmd_ch.operation <= op;
		cmd_ch.person    <= FIELD_W'(person);
		cmd_ch.rank      <= FIELD_W'(rank);
		cmd_ch.choice    <= FIELD_W'(choice);
		do
			@(posedge clk);
		while (!cmd_ch.ready);
		rand_sent++;
	endtask

	task automatic load_row(input logic [OP_W-1:0] op, input int who, input row_kind_t kind);
		int order [PARTY];
		int j;
		int t;
		for (int i = 0; i < PARTY; i++) begin
			case (kind)
				ROW_ASCEND:  order[i] = i;
				ROW_DESCEND: order[i] = PARTY - 1 - i;
				ROW_SCATTER: order[i] = $urandom_range(PARTY - 1);
				ROW_FLAT:    order[i] = 0;
				default:     order[i] = i;
			endcase
		end
		if (kind == ROW_SHUFFLE) begin
			for (int i = PARTY - 1; i > 0; i--) begin
				j        = $urandom_range(i);
				t        = order[i];
				order[i] = order[j];
				order[j] = t;
			end
		end
		for (int i = 0; i < PARTY; i++) begin
			if (op == OP_DEPT_RANK)
				send_item(OP_DEPT_RANK, who, order[i], i);
			else
				send_item(OP_PROG_CHOICE, who, i, order[i]);
		end
	endtask

	task automatic wait_idle();
		cmd_ch.valid <= 1'b0;
		do
			@(negedge clk);
		while (outstanding != 0);
		@(posedge clk);
	endtask

	initial begin
		#3_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int pick;
		arst_n           = 1'b0;
		calm             = 1'b0;
		drained          = 1'b0;
		cmd_ch.valid     = 1'b0;
		cmd_ch.operation = OP_DEPT_RANK;
		cmd_ch.person    = '0;
		cmd_ch.rank      = '0;
		cmd_ch.choice    = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < PARTY; i++) begin
			load_row(OP_DEPT_RANK, i, ROW_ASCEND);
			load_row(OP_PROG_CHOICE, i, ROW_ASCEND);
		end
		send_item(OP_RUN, 0, 0, 0);
		for (int i = 0; i < PARTY; i++)
			load_row(OP_DEPT_RANK, i, ROW_DESCEND);
		send_item(OP_RUN, 7, 7, 7);
		send_item(OP_NOISE, 7, 7, 7);
		load_row(OP_PROG_CHOICE, 7, ROW_FLAT);
		load_row(OP_DEPT_RANK, 0, ROW_FLAT);
		send_item(OP_RUN, 0, 7, 0);
		send_item(OP_RUN, 7, 0, 7);

		while (rand_sent < RAND_ITEMS) begin
			if (!drained && rand_sent >= RAND_ITEMS / 2) begin
				wait_idle();
				drained = 1'b1;
			end
			calm <= (rand_sent >= 300 && rand_sent < 400);
			pick = $urandom_range(99);
			if (pick < 25)
				send_item(OP_RUN, $urandom_range(7), $urandom_range(7), $urandom_range(7));
			else if (pick < 50)
				load_row(OP_DEPT_RANK, $urandom_range(PARTY - 1),
					($urandom_range(4) == 0) ? ROW_SCATTER : ROW_SHUFFLE);
			else if (pick < 75)
				load_row(OP_PROG_CHOICE, $urandom_range(PARTY - 1),
					($urandom_range(4) == 0) ? ROW_SCATTER : ROW_SHUFFLE);
			else if (pick < 90)
				send_item($urandom_range(1) ? OP_DEPT_RANK : OP_PROG_CHOICE,
					$urandom_range(7), $urandom_range(7), $urandom_range(7));
			else
				send_item(OP_NOISE, $urandom_range(7), $urandom_range(7), $urandom_range(7));
		end
		calm <= 1'b0;

		wait_idle();
		repeat (300) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== files.f =====
src/sme_pkg.sv
src/sme_in_if.sv
src/sme_out_if.sv
src/sme_ram.sv
src/stable_matching_engine_unit.sv
sim/sme_match_checker.sv
sim/stable_matching_engine_unit_tb.sv
